// ===== sv/dshot_pkg.sv =====
// ----------------------------------------------------------------------------
// dshot_pkg: shared types and constants of the dshot frame encoder
// Frame geometry, configuration register indexes and the poll decision struct.
// ----------------------------------------------------------------------------
package dshot_pkg;

    // frame geometry
    localparam int MAX_CHANNELS = 4;
    localparam int FRAME_BITS   = 16;
    localparam int SLOT_W       = 4;
    localparam int THR_W        = 11;
    localparam int DUTY_W       = 16;
    localparam int BIT0_W       = 15;
    localparam int CHAN_W       = 2;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIT0_DUTY    = 2'd0,
        CFG_TLM_ENABLED  = 2'd1,
        CFG_BIDIR_INVERT = 2'd2
    } t_cfg_idx;

    localparam logic [SLOT_W-1:0] SLOT_LAST   = SLOT_W'(FRAME_BITS - 1);
    localparam logic [BIT0_W-1:0] BIT0_RESET  = BIT0_W'(93);

    // telemetry poll decision for one item
    typedef struct packed {
        logic [MAX_CHANNELS-1:0] tlm_mask;
        logic                    started;
        logic [CHAN_W-1:0]       channel;
    } t_poll;

endpackage

// ===== sv/dshot_lane.sv =====
// ----------------------------------------------------------------------------
// dshot_lane: one motor channel of the frame encoder
// Builds the 16-bit word (throttle, telemetry bit, checksum) and shifts it
// out msb first, one bit per shift.
// ----------------------------------------------------------------------------
module dshot_lane
    import dshot_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_load,
    input  logic             i_shift,
    input  logic [THR_W-1:0] i_throttle,
    input  logic             i_tlm,
    input  logic             i_bidir_invert,
    output logic             o_bit
);

    logic [THR_W:0]        value;
    logic [3:0]            csum;
    logic [FRAME_BITS-1:0] r_word;
    logic [FRAME_BITS-1:0] n_word;

    // 12-bit value and nibble checksum
    always_comb begin
        value = {i_throttle, i_tlm};
        csum  = value[3:0] ^ value[7:4] ^ value[11:8];
        if (i_bidir_invert) begin
            csum = ~csum;
        end
    end

    // load has priority over shift: a new frame replaces the spent word
    always_comb begin
        n_word = r_word;
        if (i_load) begin
            n_word = {value, csum};
        end else if (i_shift) begin
            n_word = {r_word[FRAME_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_bit = r_word[FRAME_BITS-1];

endmodule

// ===== sv/dshot_poll.sv =====
// ----------------------------------------------------------------------------
// dshot_poll: telemetry query tracking
// Round-robin channel choice, pending query flag and per-channel telemetry
// bits for the item being accepted.
// ----------------------------------------------------------------------------
module dshot_poll
    import dshot_pkg::*;
#(
    parameter int CHANNELS = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_accept,
    input  logic  i_special_command,
    input  logic  i_reply_done,
    input  logic  i_tlm_enabled,
    output t_poll o_poll
);

    localparam logic [CHAN_W-1:0] CHAN_LAST = CHAN_W'(CHANNELS - 1);

    logic [CHAN_W-1:0] r_poll_channel;
    logic [CHAN_W-1:0] n_poll_channel;
    logic              r_pending;
    logic              n_pending;
    logic              pending_now;

    // decision for the item on the input
    always_comb begin
        pending_now    = r_pending && !i_reply_done;
        n_poll_channel = r_poll_channel;
        n_pending      = pending_now;
        o_poll         = '0;
        if (i_special_command && i_tlm_enabled) begin
            for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
                o_poll.tlm_mask[ch] = (ch < CHANNELS);
            end
        end
        if (i_tlm_enabled && !pending_now) begin
            n_pending      = 1'b1;
            n_poll_channel = (r_poll_channel == CHAN_LAST) ? '0 : r_poll_channel + 1'b1;
            o_poll.tlm_mask[n_poll_channel] = 1'b1;
            o_poll.started = 1'b1;
        end
        o_poll.channel = n_poll_channel;
    end

    // state moves only with an accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_channel <= '0;
            r_pending      <= 1'b0;
        end else if (i_accept) begin
            r_poll_channel <= n_poll_channel;
            r_pending      <= n_pending;
        end
    end

endmodule

// ===== sv/dshot_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// dshot_frame_encoder: four-channel dshot frame encoder with 4-bit checksum
// Turns one throttle item into sixteen bit slots of per-channel pwm duties.
// ----------------------------------------------------------------------------
// Each accepted item yields 16 result items, one per cycle when the output is
// not stalled: one per bit slot, as the lane shift registers move one bit of
// each channel word into the output register with each slot. The next item is
// accepted in the same cycle as the last bit slot of the current one enters
// the output register, so frames follow each other with no gap. The user must
// write configuration only between items; the block itself does not enforce it.
module dshot_frame_encoder
    import dshot_pkg::*;
#(
    parameter int CHANNELS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [THR_W-1:0]      i_throttle_ch0,
    input  logic [THR_W-1:0]      i_throttle_ch1,
    input  logic [THR_W-1:0]      i_throttle_ch2,
    input  logic [THR_W-1:0]      i_throttle_ch3,
    input  logic                  i_special_command,
    input  logic                  i_reply_done,
    // output channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [SLOT_W-1:0]     o_bit_slot,
    output logic [DUTY_W-1:0]     o_duty_ch0,
    output logic [DUTY_W-1:0]     o_duty_ch1,
    output logic [DUTY_W-1:0]     o_duty_ch2,
    output logic [DUTY_W-1:0]     o_duty_ch3,
    output logic                  o_last_bit,
    output logic [CHAN_W-1:0]     o_polled_channel,
    output logic                  o_poll_started
);

    // configuration registers
    logic [BIT0_W-1:0] r_bit0_duty;
    logic              r_tlm_enabled;
    logic              r_bidir_invert;

    // frame sequencing
    logic              r_busy;
    logic              n_busy;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;
    logic [CHAN_W-1:0] r_frame_channel;
    logic              r_frame_started;
    logic              in_accept;
    logic              out_load;

    // output register
    logic              r_valid;
    logic              n_valid;
    logic [SLOT_W-1:0] r_bit_slot;
    logic [DUTY_W-1:0] r_duty [MAX_CHANNELS];
    logic              r_last;
    logic [CHAN_W-1:0] r_polled;
    logic              r_started;

    logic [THR_W-1:0]        throttle [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] lane_bit;
    logic [DUTY_W-1:0]       lane_duty [MAX_CHANNELS];
    t_poll                   poll;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit0_duty    <= BIT0_RESET;
            r_tlm_enabled  <= 1'b0;
            r_bidir_invert <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BIT0_DUTY:    r_bit0_duty    <= i_cfg_data;
                CFG_TLM_ENABLED:  r_tlm_enabled  <= i_cfg_data[0];
                CFG_BIDIR_INVERT: r_bidir_invert <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // handshake: a slot moves out when the output register is free
    assign out_load  = r_busy && (!r_valid || !i_stall);
    assign o_stall   = r_busy && !(out_load && (r_slot == SLOT_LAST));
    assign in_accept = i_valid && !o_stall;

    // telemetry poll decision
    dshot_poll #(
        .CHANNELS (CHANNELS)
    ) u_poll (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (in_accept),
        .i_special_command (i_special_command),
        .i_reply_done      (i_reply_done),
        .i_tlm_enabled     (r_tlm_enabled),
        .o_poll            (poll)
    );

    assign throttle[0] = i_throttle_ch0;
    assign throttle[1] = i_throttle_ch1;
    assign throttle[2] = i_throttle_ch2;
    assign throttle[3] = i_throttle_ch3;

    // one lane per channel, unused channels give zero duty
    for (genvar ch = 0; ch < MAX_CHANNELS; ch++) begin : g_lane
        if (ch < CHANNELS) begin : g_used
            dshot_lane u_lane (
                .i_clk          (i_clk),
                .i_load         (in_accept),
                .i_shift        (out_load),
                .i_throttle     (throttle[ch]),
                .i_tlm          (poll.tlm_mask[ch]),
                .i_bidir_invert (r_bidir_invert),
                .o_bit          (lane_bit[ch])
            );
            assign lane_duty[ch] = lane_bit[ch] ? {r_bit0_duty, 1'b0} : {1'b0, r_bit0_duty};
        end else begin : g_unused
            assign lane_bit[ch]  = 1'b0;
            assign lane_duty[ch] = '0;
        end
    end

    // frame sequencer
    always_comb begin
        n_busy = r_busy;
        n_slot = r_slot;
        if (out_load) begin
            n_slot = r_slot + 1'b1;
            if (r_slot == SLOT_LAST) begin
                n_busy = 1'b0;
            end
        end
        if (in_accept) begin
            n_busy = 1'b1;
            n_slot = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_slot <= '0;
        end else begin
            r_busy <= n_busy;
            r_slot <= n_slot;
        end
    end

    // per-frame poll report
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_frame_channel <= poll.channel;
            r_frame_started <= poll.started;
        end
    end

    // merge the lanes into the output register
    always_comb begin
        n_valid = r_valid && i_stall;
        if (out_load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_bit_slot <= r_slot;
            r_last     <= (r_slot == SLOT_LAST);
            r_polled   <= r_frame_channel;
            r_started  <= r_frame_started;
            for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
                r_duty[ch] <= lane_duty[ch];
            end
        end
    end

    assign o_valid          = r_valid;
    assign o_bit_slot       = r_bit_slot;
    assign o_duty_ch0       = r_duty[0];
    assign o_duty_ch1       = r_duty[1];
    assign o_duty_ch2       = r_duty[2];
    assign o_duty_ch3       = r_duty[3];
    assign o_last_bit       = r_last;
    assign o_polled_channel = r_polled;
    assign o_poll_started   = r_started;

`ifndef SYNTH
    // a new item always starts at the first bit slot
    a_accept_starts_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_busy && (r_slot == '0))
        else $error("frame did not start at slot zero");

    // within a frame, a taken slot is followed by the next slot
    a_slot_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_bit) |=>
        (o_valid && (o_bit_slot == SLOT_W'($past(o_bit_slot) + 1'b1))))
        else $error("bit slot sequence broken");

    // the slot counter rests at zero between frames
    a_idle_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_slot == '0))
        else $error("slot counter not at zero while idle");
`endif

endmodule
